// ===== design/ordered_array_list_defines.svh =====
// Assertion macros used by the checker file, oal_checker.sv.
`ifndef ORDERED_ARRAY_LIST_DEFINES_SVH
`define ORDERED_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define OAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define OAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/oal_pkg.sv =====
package oal_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BADPOS   = 2'd2,
    STAT_NOTFOUND = 2'd3
  } stat_t;

  typedef struct packed {
    cmd_t       command;
    logic [5:0] position;
    logic [7:0] element;
  } req_t;

  typedef struct packed {
    stat_t      status;
    logic [5:0] found_index;
    logic [6:0] length;
  } rsp_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request
    logic exec;   // commit command
  } ctl_t;

endpackage

// ===== design/oal_ctrl.sv =====
module oal_ctrl import oal_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.exec;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.load = 1'b0;
    ctl.exec = 1'b0;
    busy     = 1'b1;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/oal_datapath.sv =====
module oal_datapath import oal_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic clk,
  input  logic rst,
  input  ctl_t ctl,
  input  req_t request,
  output rsp_t result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  req_t       req;
  logic [7:0] entries      [CAPACITY];
  logic [7:0] entries_next [CAPACITY];
  logic [CW-1:0] count, count_next;
  rsp_t       rsp_next;

  always_ff @(posedge clk) begin
    if (ctl.load) req <= request;
    if (ctl.exec) begin
      entries <= entries_next;
      result  <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.exec) begin
      count <= count_next;
    end
  end

  always_comb begin
    logic [6:0] pos7;
    logic [6:0] cnt7;
    logic       ins_ok;
    logic       del_ok;
    logic       found;
    logic [5:0] idx;
    int         lo;
    int         hi;

    pos7   = {1'b0, req.position};
    cnt7   = 7'(count);
    ins_ok = 1'b0;
    del_ok = 1'b0;
    found  = 1'b0;
    idx    = '0;
    count_next = count;
    rsp_next.status      = STAT_OK;
    rsp_next.found_index = '0;

    // first match wins: scan from the top down
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if ((7'(k) < cnt7) && (entries[k] == req.element)) begin
        found = 1'b1;
        idx   = 6'(k);
      end
    end

    case (req.command)
      CMD_INSERT: begin
        if (cnt7 >= 7'(CAPACITY)) begin
          rsp_next.status = STAT_FULL;
        end else if ((pos7 == 7'd0) || (pos7 > cnt7 + 7'd1)) begin
          rsp_next.status = STAT_BADPOS;
        end else begin
          ins_ok     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      CMD_DELETE: begin
        if ((pos7 == 7'd0) || (pos7 > cnt7)) begin
          rsp_next.status = STAT_BADPOS;
        end else begin
          del_ok     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      CMD_FIND: begin
        if (found) begin
          rsp_next.found_index = idx;
        end else begin
          rsp_next.status = STAT_NOTFOUND;
        end
      end
      default: begin
        rsp_next.status = STAT_OK;
      end
    endcase

    rsp_next.length = 7'(count_next);

    // each cell picks itself, its lower or its upper neighbor, or the new element
    for (int k = 0; k < CAPACITY; k++) begin
      lo = (k == 0) ? 0 : k - 1;
      hi = (k == CAPACITY - 1) ? k : k + 1;
      entries_next[k] = entries[k];
      if (ins_ok) begin
        if (7'(k) == pos7 - 7'd1) begin
          entries_next[k] = req.element;
        end else if ((7'(k) > pos7 - 7'd1) && (7'(k) <= cnt7)) begin
          entries_next[k] = entries[IW'(lo)];
        end
      end else if (del_ok) begin
        if ((7'(k) >= pos7 - 7'd1) && (7'(k) + 7'd1 < cnt7)) begin
          entries_next[k] = entries[IW'(hi)];
        end
      end
    end
  end

endmodule

// ===== design/ordered_array_list.sv =====
// Ordered byte list, up to CAPACITY entries, with insert / delete / find.
// A command is taken when start is high and busy is low; request carries
// command, 1-based position (insert, delete) and element (insert, find).
// A command runs in a capture step, which registers the request, and then an
// execute step in which the whole row of entry cells shifts (insert up, delete
// down) and compares against the element in parallel. done pulses for one cycle
// in the cycle after the execute step, with status, found_index and length on
// result; the receiver cannot stall, so result must be taken while done is high.
// busy is already low in that cycle, so the next command can be taken then.
// Status: ok, full (insert into a full list, checked first), bad position,
// not found (find; found_index is 0). Command code 3 changes nothing and
// reports ok with the current length. Entries hold no reset value; only
// those below the length are ever looked at.
module ordered_array_list import oal_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output rsp_t result
);

  ctl_t ctl;

  // sequencer: idle / execute, plus the done strobe
  oal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  // entry cells, length count and result register
  oal_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .request (request),
    .result  (result)
  );

endmodule

// ===== design/oal_checker.sv =====
`include "ordered_array_list_defines.svh"

module oal_checker import oal_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  logic accepted;

  assign accepted = start && !busy;

  `OAL_ASSERT_NEXT(a_busy_after_accept, accepted, busy && !done, "no busy after transaction accept")
  `OAL_ASSERT_NEXT(a_done_follows, accepted, ##1 done, "done missing two cycles after accept")
  `OAL_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `OAL_ASSERT_NOW(a_len_bound, done, result.length <= 7'(CAPACITY), "length above capacity")
  `OAL_ASSERT_NOW(a_full_len, done && (result.status == STAT_FULL), result.length == 7'(CAPACITY), "full reported below capacity")

endmodule

bind ordered_array_list oal_checker #(
  .CAPACITY (CAPACITY)
) u_oal_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== dv/tb_ordered_array_list.sv =====
`timescale 1ns / 1ps

// Testbench for ordered_array_list: a list of byte entries with insert, delete
// and find, one command per start/busy transaction, one result per done pulse.
module tb_ordered_array_list;
  import oal_pkg::*;

  localparam int CAPACITY    = 8;
  localparam int NUM_RANDOM  = 400;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_TAIL  = 8;      // extra wait after the drain to catch stray done pulses
  localparam int QUIET_FIRST = 150;    // random items run with no idle cycles
  localparam int QUIET_LAST  = 260;

  // Tracks the list contents as each command is accepted and holds the
  // results that the block owes, oldest first.
  class list_tracker;
    logic [7:0] cells [CAPACITY];
    int         fill;
    rsp_t       pending_results [$];
    int         fails;

    function new();
      fill  = 0;
      fails = 0;
      foreach (cells[i]) cells[i] = 8'h00;
    endfunction

    // Apply one accepted command to the tracked list and queue its result.
    function void note_command(req_t r);
      rsp_t want;
      int   k;
      int   pos;
      want.status      = STAT_OK;
      want.found_index = '0;
      pos              = int'(r.position);
      case (r.command)
        CMD_INSERT: begin
          // full takes priority over a bad position
          if (fill >= CAPACITY) begin
            want.status = STAT_FULL;
          end else if (pos < 1 || pos > fill + 1) begin
            want.status = STAT_BADPOS;
          end else begin
            for (k = fill; k >= pos; k--) cells[k] = cells[k-1];
            cells[pos-1] = r.element;
            fill++;
          end
        end
        CMD_DELETE: begin
          if (pos < 1 || pos > fill) begin
            want.status = STAT_BADPOS;
          end else begin
            for (k = pos; k < fill; k++) cells[k-1] = cells[k];
            fill--;
          end
        end
        CMD_FIND: begin
          want.status = STAT_NOTFOUND;
          for (k = 0; k < fill; k++) begin
            if (want.status == STAT_NOTFOUND && cells[k] == r.element) begin
              want.status      = STAT_OK;
              want.found_index = k[5:0];
            end
          end
        end
        default: ;  // no-op code: list untouched, ok status
      endcase
      want.length = fill[6:0];
      pending_results.push_back(want);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result with nothing outstanding: status=%0d idx=%0d len=%0d",
                   $time, got.status, got.found_index, got.length);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.found_index !== want.found_index ||
          got.length !== want.length) begin
        fails++;
        if (fails <= 10)
          $display("%0t: mismatch: status exp %0d got %0d, idx exp %0d got %0d, len exp %0d got %0d",
                   $time, want.status, got.status, want.found_index, got.found_index,
                   want.length, got.length);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  list_tracker tracker = new();

  ordered_array_list #(.CAPACITY(CAPACITY)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or stops answering.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL ordered_array_list");
    $finish;
  end

  // Results cannot be held off, so every done pulse is checked at the edge
  // that ends its cycle. Values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(result);
  end

  // One command transaction. Optional idle cycles first (start low), then
  // start stays up until an edge sees busy low; that edge is the accept.
  // Exactly one NBA to start per edge, so back-to-back commands keep it high.
  task automatic send_command(input req_t r, input bit allow_idle);
    int gap;
    gap = 0;
    if (allow_idle) begin
      while ($urandom_range(99) < 36) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    tracker.note_command(r);
  endtask

  task automatic issue(input cmd_t c, input logic [5:0] p, input logic [7:0] e);
    req_t r;
    r.command  = c;
    r.position = p;
    r.element  = e;
    send_command(r, 1'b1);
  endtask

  // Random command, mostly well formed against the tracked list so that it
  // spends time both near empty and at full. grow picks the drift direction.
  function automatic req_t random_command(bit grow);
    req_t r;
    int   pick;
    int   fill;
    fill       = tracker.fill;
    pick       = $urandom_range(99);
    r.position = 6'($urandom_range(63));
    // half the elements come from a tiny set so finds hit duplicates
    r.element  = ($urandom_range(1)) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    if (pick < 5) begin
      r.command = CMD_NOP;
    end else if (pick < 17) begin
      // noise: any real command, any position
      r.command = cmd_t'($urandom_range(2));
    end else begin
      pick = $urandom_range(99);
      if (pick < (grow ? 60 : 25)) begin
        r.command  = CMD_INSERT;
        r.position = 6'($urandom_range(fill + 1, 1));
      end else if (pick < 80 && fill > 0) begin
        r.command  = CMD_DELETE;
        r.position = 6'($urandom_range(fill, 1));
      end else begin
        r.command = CMD_FIND;
        if (fill > 0 && $urandom_range(99) < 60)
          r.element = tracker.cells[$urandom_range(fill - 1)];
      end
    end
    return r;
  endfunction

  initial begin
    int   n;
    bit   grow;
    req_t r;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-list errors, position edges, fill to full, full ranks
    // above bad position, first of duplicates, misses, no-op, delete ends.
    issue(CMD_FIND,   6'd0,  8'h00);   // find on empty list
    issue(CMD_DELETE, 6'd1,  8'h00);   // delete on empty list
    issue(CMD_INSERT, 6'd0,  8'h12);   // position zero
    issue(CMD_INSERT, 6'd2,  8'h12);   // one past length+1
    issue(CMD_INSERT, 6'd1,  8'h00);
    issue(CMD_INSERT, 6'd2,  8'hFF);   // append
    issue(CMD_INSERT, 6'd1,  8'h5A);   // front
    issue(CMD_INSERT, 6'd2,  8'hA5);   // middle
    issue(CMD_INSERT, 6'd5,  8'h5A);   // duplicate at the end
    issue(CMD_INSERT, 6'd3,  8'h01);
    issue(CMD_INSERT, 6'd7,  8'h80);
    issue(CMD_INSERT, 6'd8,  8'h7F);   // now full
    issue(CMD_INSERT, 6'd63, 8'h11);   // full
    issue(CMD_INSERT, 6'd0,  8'h11);   // full beats bad position
    issue(CMD_FIND,   6'd63, 8'h5A);   // first of two matches
    issue(CMD_FIND,   6'd0,  8'h7F);   // last slot
    issue(CMD_FIND,   6'd5,  8'h33);   // miss
    issue(CMD_NOP,    6'd63, 8'hFF);
    issue(CMD_DELETE, 6'd0,  8'hFF);
    issue(CMD_DELETE, 6'd9,  8'h00);   // length+1
    issue(CMD_DELETE, 6'd63, 8'h00);
    issue(CMD_DELETE, 6'd8,  8'h00);   // last entry
    issue(CMD_DELETE, 6'd1,  8'h00);   // first entry
    issue(CMD_DELETE, 6'd3,  8'h00);   // middle
    issue(CMD_FIND,   6'd0,  8'hFF);

    // Random part; no-ops are sent but not counted.
    n    = 0;
    grow = 1'b1;
    while (n < NUM_RANDOM) begin
      if (tracker.fill >= CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
      if (tracker.fill == 0 && $urandom_range(1) == 0) grow = 1'b1;
      r = random_command(grow);
      send_command(r, !(n >= QUIET_FIRST && n < QUIET_LAST));
      if (r.command != CMD_NOP) n++;
    end
    start <= 1'b0;

    // Drain, then a short tail to catch any stray done pulse.
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (tracker.fails == 0 && tracker.outstanding() == 0) begin
      $display("PASS ordered_array_list");
    end else begin
      $display("FAIL ordered_array_list");
    end
    $finish;
  end

endmodule
